// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the timer queue back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/stq_pkg.sv -----
// package for the sorted timer queue: codes and payload types
package stq_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int ID_BITS_DEF = 16;
    localparam int FIELD_TIME = 48;
    localparam int FIELD_ID = 16;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [FIELD_TIME-1:0] now_time;
        logic [FIELD_TIME-1:0] start_time;
        logic [FIELD_TIME-1:0] period;
        logic [FIELD_ID-1:0] remove_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [FIELD_ID-1:0] timer_id;
        logic expired;
        logic queue_empty;
        logic [FIELD_TIME-1:0] next_delay;
        logic last;
    } rsp_t;
endpackage

// ----- hw/rtl/stq_cmd_if.sv -----
// valid/ready channel interfaces for commands and results
interface stq_cmd_if;
    logic valid;
    logic ready;
    stq_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stq_rsp_if;
    logic valid;
    logic ready;
    stq_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/stq_front.sv -----
// front end: accepts commands into a two-entry queue
module stq_front (
    input  logic clk,
    input  logic rst_n,
    stq_cmd_if.sink cmd,
    output logic q_valid,
    output stq_pkg::cmd_t q_data,
    input  logic q_pop
);
    stq_pkg::cmd_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rd_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            mem_reg[wr_reg] <= cmd.data;
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                wr_reg <= ~wr_reg;
            if (q_pop && q_valid)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'((cmd.valid && cmd.ready) ? 1 : 0)
                - 2'((q_pop && q_valid) ? 1 : 0);
        end
    end
endmodule

// ----- hw/rtl/stq_back.sv -----
// back end: sorted queue, free list and tick walk
`include "assert_macros.svh"
module stq_back #(
    parameter int SLOTS = stq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS = stq_pkg::ID_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  stq_pkg::cmd_t q_data,
    output logic q_pop,
    stq_rsp_if.source rsp
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_SCAN, S_SHIFT, S_FINAL, S_EMIT,
        S_TPOP, S_TFIRE, S_REARM, S_REMOVE
    } state_t;

    state_t state_reg;
    stq_pkg::cmd_t cmd_reg;
    logic [TIME_BITS-1:0] dl_mem [SLOTS];
    logic [TIME_BITS-1:0] per_mem [SLOTS];
    logic [ID_BITS-1:0] id_reg [SLOTS];
    logic [SW-1:0] ord_reg [SLOTS];
    logic [SW-1:0] free_reg [SLOTS];
    logic [CW-1:0] qcnt_reg, fcnt_reg, pos_reg;
    logic [ID_BITS-1:0] last_id_reg;
    logic [SW-1:0] slot_reg;
    logic [TIME_BITS-1:0] key_reg;
    logic [CW-1:0] due_reg;
    logic [SLOTS-1:0] fired_reg;
    logic [1:0] st_reg;
    logic [ID_BITS-1:0] rid_reg;
    logic back_reg;
    logic out_valid_reg;
    stq_pkg::rsp_t out_reg;

    logic [TIME_BITS-1:0] now_t;
    logic [ID_BITS-1:0] cand0, cand1, new_id, m1, tid;
    logic [ID_BITS:0] sum_id;
    logic [TIME_BITS:0] rearm;
    logic [SW-1:0] rm_idx;
    logic [TIME_BITS-1:0] head_dl;

    assign now_t = TIME_BITS'(cmd_reg.now_time);
    assign tid = ID_BITS'(cmd_reg.remove_id);
    assign rm_idx = SW'((tid - ID_BITS'(1)) % SLOTS);

    // id generation for the slot at the head of the free list
    always_comb
    begin
        m1 = (last_id_reg != '0) ? last_id_reg - ID_BITS'(1) : '0;
        cand0 = ID_BITS'((m1 / SLOTS) * SLOTS) + ID_BITS'(free_reg[0]) + ID_BITS'(1);
        sum_id = {1'b0, cand0} + (ID_BITS+1)'(SLOTS);
        cand1 = (cand0 <= last_id_reg) ? sum_id[ID_BITS-1:0] : cand0;
        new_id = (cand1 < last_id_reg) ? ID_BITS'(free_reg[0]) + ID_BITS'(1) : cand1;
    end

    assign rearm = {1'b0, now_t} + {1'b0, per_mem[slot_reg]};
    assign head_dl = dl_mem[ord_reg[0]];
    assign q_pop = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    // payload memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD && cmd_reg.start_time != '0 && fcnt_reg != '0)
        begin
            dl_mem[free_reg[0]] <= TIME_BITS'(cmd_reg.start_time);
            per_mem[free_reg[0]] <= TIME_BITS'(cmd_reg.period);
        end
        else if (state_reg == S_REARM && per_mem[slot_reg] != '0)
            dl_mem[slot_reg] <= rearm[TIME_BITS] ? TMAX : rearm[TIME_BITS-1:0];
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            qcnt_reg <= '0;
            fcnt_reg <= CW'(SLOTS);
            last_id_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                id_reg[i] <= '0;
                free_reg[i] <= SW'(i);
                ord_reg[i] <= '0;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (q_pop)
                    begin
                        cmd_reg <= q_data;
                        st_reg <= stq_pkg::ST_OK;
                        rid_reg <= '0;
                        unique case (q_data.action)
                            stq_pkg::ACT_ADD: state_reg <= S_ADD;
                            stq_pkg::ACT_REMOVE: state_reg <= S_REMOVE;
                            stq_pkg::ACT_TICK:
                            begin
                                fired_reg <= '0;
                                state_reg <= S_TPOP;
                            end
                            default:
                            begin
                                st_reg <= stq_pkg::ST_REJECT;
                                state_reg <= S_FINAL;
                            end
                        endcase
                    end
                S_ADD:
                    if (cmd_reg.start_time == '0 || fcnt_reg == '0)
                    begin
                        st_reg <= stq_pkg::ST_REJECT;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        slot_reg <= free_reg[0];
                        key_reg <= TIME_BITS'(cmd_reg.start_time);
                        id_reg[free_reg[0]] <= new_id;
                        last_id_reg <= new_id;
                        rid_reg <= new_id;
                        for (int i = 0; i < SLOTS - 1; i++)
                            free_reg[i] <= free_reg[i+1];
                        fcnt_reg <= fcnt_reg - CW'(1);
                        pos_reg <= '0;
                        back_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                // find insert position, one entry a cycle
                S_SCAN:
                    if (pos_reg < qcnt_reg && dl_mem[ord_reg[pos_reg[SW-1:0]]] <= key_reg)
                        pos_reg <= pos_reg + CW'(1);
                    else
                        state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    for (int i = 1; i < SLOTS; i++)
                        if (CW'(i) > pos_reg && CW'(i) <= qcnt_reg)
                            ord_reg[i] <= ord_reg[i-1];
                    ord_reg[pos_reg[SW-1:0]] <= slot_reg;
                    qcnt_reg <= qcnt_reg + CW'(1);
                    state_reg <= back_reg ? S_TFIRE : S_FINAL;
                end
                S_REMOVE:
                    if (tid == '0 || id_reg[rm_idx] != tid)
                    begin
                        st_reg <= stq_pkg::ST_NOT_FOUND;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS - 1; i++)
                            if (CW'(i) < qcnt_reg)
                            begin
                                logic hit;
                                hit = 1'b0;
                                for (int j = 0; j <= i; j++)
                                    if (ord_reg[j] == rm_idx && CW'(j) < qcnt_reg)
                                        hit = 1'b1;
                                if (hit)
                                    ord_reg[i] <= ord_reg[i+1];
                            end
                        qcnt_reg <= qcnt_reg - CW'(1);
                        id_reg[rm_idx] <= '0;
                        free_reg[fcnt_reg[SW-1:0]] <= rm_idx;
                        fcnt_reg <= fcnt_reg + CW'(1);
                        state_reg <= S_FINAL;
                    end
                // take the head if it is due and has not fired this tick
                S_TPOP:
                    if (qcnt_reg != '0 && head_dl <= now_t && !fired_reg[ord_reg[0]])
                    begin
                        slot_reg <= ord_reg[0];
                        fired_reg[ord_reg[0]] <= 1'b1;
                        for (int i = 0; i < SLOTS - 1; i++)
                            ord_reg[i] <= ord_reg[i+1];
                        qcnt_reg <= qcnt_reg - CW'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_FINAL;
                S_EMIT:
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{status: stq_pkg::ST_OK,
                            timer_id: stq_pkg::FIELD_ID'(id_reg[slot_reg]),
                            expired: 1'b1, queue_empty: 1'b0, next_delay: '0, last: 1'b0};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_REARM;
                    end
                S_REARM:
                    if (per_mem[slot_reg] != '0)
                    begin
                        key_reg <= rearm[TIME_BITS] ? TMAX : rearm[TIME_BITS-1:0];
                        pos_reg <= '0;
                        back_reg <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        id_reg[slot_reg] <= '0;
                        free_reg[fcnt_reg[SW-1:0]] <= slot_reg;
                        fcnt_reg <= fcnt_reg + CW'(1);
                        state_reg <= S_TPOP;
                    end
                S_TFIRE:
                    state_reg <= S_TPOP;
                S_FINAL:
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{status: st_reg,
                            timer_id: stq_pkg::FIELD_ID'(rid_reg), expired: 1'b0,
                            queue_empty: (qcnt_reg == '0),
                            next_delay: (qcnt_reg != '0 && head_dl > now_t)
                                ? stq_pkg::FIELD_TIME'(head_dl - now_t) : '0,
                            last: 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, (qcnt_reg + fcnt_reg) <= CW'(SLOTS))
    `ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE && !out_valid_reg)
    `ASSERT_NXT(a_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
endmodule

// ----- hw/rtl/sorted_timer_queue.sv -----
// top level of the deadline-sorted timer queue
//  channel | dir | payload
//  cmd     | in  | action, now_time, start_time, period, remove_id
//  rsp     | out | status, timer_id, expired, queue_empty, next_delay, last
// add: after the pop, the insert scan walks past each queued timer at or before the new deadline
// remove: looks up the id and unlinks its slot; tick: each fired one-shot timer is freed and
//   each re-armed timer goes through the insert scan again; each result also waits for rsp.ready
// reset clears counts, ids and the free list at once; no clearing pass
// a two-entry command queue keeps accepting, until it is full, while the back end stalls on rsp
module sorted_timer_queue #(
    parameter int SLOTS = stq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF,
    parameter int ID_BITS = stq_pkg::ID_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    stq_cmd_if.sink cmd,
    stq_rsp_if.source rsp
);
    logic q_valid, q_pop;
    stq_pkg::cmd_t q_data;

    stq_front u_front (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    stq_back #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .rsp(rsp)
    );
endmodule
